// ----- hdl/rds_station_name_decoder_macros.svh -----
// Assertion macros shared by the station name decoder RTL.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef RDS_STATION_NAME_DECODER_MACROS_SVH
`define RDS_STATION_NAME_DECODER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RDSN_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rds station name decoder assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define RDSN_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rds station name decoder assertion failed");

`endif

// ----- hdl/rdsn_pkg.sv -----
// Types, constants and the per-character update rule of the station name decoder.
// Used by the channel interfaces and all decoder modules; no dependencies.
package rdsn_pkg;

   localparam int NAME_ROWS = 4;
   localparam int ROW_W = 2;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [7:0] SPACE_CHAR = 8'h20;
   localparam logic [7:0] PRINT_LOW = 8'h20;
   localparam logic [7:0] PRINT_HIGH = 8'h7E;
   localparam logic [15:0] GROUP_MASK = 16'hF800;
   localparam logic [15:0] GROUP_0A = 16'h0000;
   localparam logic [15:0] GROUP_0B = 16'h0800;
   localparam logic DOUBLE_BUFFER_RESET = 1'b1;

   typedef enum logic {
      OP_DECODE = 1'b0,
      OP_CLEAR  = 1'b1
   } op_type;

   typedef enum logic {
      REG_DOUBLE_BUFFER = 1'b0
   } reg_index_type;

   typedef logic [7:0] char_type;

   typedef struct packed {
      char_type first;
      char_type second;
   } pair_type;

   typedef struct packed {
      char_type shown;
      char_type candidate;
   } slot_type;

   typedef struct packed {
      logic        operation;
      logic [15:0] block_b;
      logic [15:0] block_d;
   } req_word_type;

   typedef struct packed {
      logic             accepted;
      logic [ROW_W-1:0] segment;
      char_type         shown_first;
      char_type         shown_second;
   } rsp_word_type;

   typedef struct packed {
      logic             enable;
      logic             clear;
      logic             accepted;
      logic [ROW_W-1:0] row;
      pair_type         chars;
   } step_type;

   function automatic slot_type put_char(slot_type cur, char_type c, logic double_buffer);
      slot_type nxt;
      nxt = cur;
      if (cur.candidate == c) begin
         nxt.shown = c;
      end else if (c inside {[PRINT_LOW:PRINT_HIGH]}) begin
         if (double_buffer) begin
            nxt.candidate = c;
         end else begin
            nxt.shown = c;
         end
      end
      return nxt;
   endfunction

endpackage

// ----- hdl/rdsn_channels.sv -----
// Valid/ready channel interfaces for the group words and the result words.
// Depends on rdsn_pkg for the field widths.
interface rdsn_req_if;
   logic        valid;
   logic        ready;
   logic        operation;
   logic [15:0] block_b;
   logic [15:0] block_d;

   modport source (output valid, output operation, output block_b, output block_d,
                   input ready);
   modport sink (input valid, input operation, input block_b, input block_d,
                 output ready);
endinterface

interface rdsn_rsp_if;
   logic                       valid;
   logic                       ready;
   logic                       accepted;
   logic [rdsn_pkg::ROW_W-1:0] segment;
   rdsn_pkg::char_type         shown_first;
   rdsn_pkg::char_type         shown_second;

   modport source (output valid, output accepted, output segment, output shown_first,
                   output shown_second, input ready);
   modport sink (input valid, input accepted, input segment, input shown_first,
                 input shown_second, output ready);
endinterface

// ----- hdl/rdsn_csr.sv -----
// APB-style configuration register block holding the double buffering enable.
// Depends on rdsn_pkg for the address width, data width and register index.
module rdsn_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [rdsn_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [rdsn_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [rdsn_pkg::CSR_DATA_W-1:0] prdata,
   output logic                            pready,
   output logic                            double_buffer
);

   logic double_buffer_ff;
   logic double_buffer_in;
   logic hit;

   assign hit = (paddr[rdsn_pkg::CSR_ADDR_W-1] == rdsn_pkg::REG_DOUBLE_BUFFER);
   assign pready = 1'b1;

   always_comb begin
      double_buffer_in = double_buffer_ff;
      if (psel && penable && pwrite && pready && hit) begin
         double_buffer_in = pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         double_buffer_ff <= rdsn_pkg::DOUBLE_BUFFER_RESET;
      end else begin
         double_buffer_ff <= double_buffer_in;
      end
   end

   always_comb begin
      prdata = '0;
      if (hit) begin
         prdata[0] = double_buffer_ff;
      end
   end

   assign double_buffer = double_buffer_ff;

endmodule

// ----- hdl/rdsn_name_store.sv -----
// Shown and candidate name stores, kept as four character pairs each, with their update.
// Depends on rdsn_pkg for the step and result words and the character update rule.
module rdsn_name_store (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   double_buffer,
   input  rdsn_pkg::step_type     step,
   output rdsn_pkg::rsp_word_type result
);

   rdsn_pkg::pair_type shown_ff [rdsn_pkg::NAME_ROWS];
   rdsn_pkg::pair_type shown_in [rdsn_pkg::NAME_ROWS];
   rdsn_pkg::pair_type cand_ff  [rdsn_pkg::NAME_ROWS];
   rdsn_pkg::pair_type cand_in  [rdsn_pkg::NAME_ROWS];

   rdsn_pkg::pair_type shown_row;
   rdsn_pkg::pair_type cand_row;
   rdsn_pkg::slot_type slot_first;
   rdsn_pkg::slot_type slot_second;
   rdsn_pkg::pair_type space_pair;

   assign space_pair = '{first: rdsn_pkg::SPACE_CHAR, second: rdsn_pkg::SPACE_CHAR};
   assign shown_row = shown_ff[step.row];
   assign cand_row = cand_ff[step.row];

   always_comb begin
      slot_first = rdsn_pkg::put_char('{shown: shown_row.first, candidate: cand_row.first},
                                      step.chars.first, double_buffer);
      slot_second = rdsn_pkg::put_char('{shown: shown_row.second, candidate: cand_row.second},
                                       step.chars.second, double_buffer);
   end

   always_comb begin
      for (int r = 0; r < rdsn_pkg::NAME_ROWS; r++) begin
         shown_in[r] = shown_ff[r];
         cand_in[r] = cand_ff[r];
      end
      if (step.enable) begin
         if (step.clear) begin
            for (int r = 0; r < rdsn_pkg::NAME_ROWS; r++) begin
               shown_in[r] = space_pair;
               cand_in[r] = space_pair;
            end
         end else if (step.accepted) begin
            shown_in[step.row] = '{first: slot_first.shown, second: slot_second.shown};
            cand_in[step.row] = '{first: slot_first.candidate, second: slot_second.candidate};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < rdsn_pkg::NAME_ROWS; r++) begin
            shown_ff[r] <= space_pair;
            cand_ff[r] <= space_pair;
         end
      end else begin
         for (int r = 0; r < rdsn_pkg::NAME_ROWS; r++) begin
            shown_ff[r] <= shown_in[r];
            cand_ff[r] <= cand_in[r];
         end
      end
   end

   always_comb begin
      result.accepted = step.accepted;
      result.segment = step.row;
      if (step.clear) begin
         result.shown_first = rdsn_pkg::SPACE_CHAR;
         result.shown_second = rdsn_pkg::SPACE_CHAR;
      end else if (step.accepted) begin
         result.shown_first = slot_first.shown;
         result.shown_second = slot_second.shown;
      end else begin
         result.shown_first = shown_row.first;
         result.shown_second = shown_row.second;
      end
   end

endmodule

// ----- hdl/rds_station_name_decoder.sv -----
// Top level of the RDS station name decoder: input register, name stores, result register.
// Depends on rdsn_pkg, rdsn_channels, rdsn_csr, rdsn_name_store and the macro header.
//
//   channel  direction  handshake          payload
//   req_ch   in         valid/ready        operation, block_b, block_d
//   rsp_ch   out        valid/ready        accepted, segment, shown_first, shown_second
//   csr      in         APB psel/penable   double_buffer_enable at byte address 0
//
// A word passes the input and then the result register; one is accepted per cycle unless stalled.
// The update of a character pair happens between the input register and the result register.
// Reset is synchronous and fills both name stores with spaces at once.
// A stalled result holds the result register; the input register then holds one more word.
`include "rds_station_name_decoder_macros.svh"

module rds_station_name_decoder (
   input  logic                            clock,
   input  logic                            reset,
   rdsn_req_if.sink                        req_ch,
   rdsn_rsp_if.source                      rsp_ch,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [rdsn_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [rdsn_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [rdsn_pkg::CSR_DATA_W-1:0] prdata,
   output logic                            pready
);

   logic                   double_buffer;
   logic                   s1_valid_ff;
   logic                   s1_valid_in;
   rdsn_pkg::req_word_type s1_word_ff;
   rdsn_pkg::req_word_type s1_word_in;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   rdsn_pkg::rsp_word_type rsp_word_ff;
   rdsn_pkg::rsp_word_type rsp_word_in;
   logic                   req_accept;
   logic                   s1_advance;
   logic [15:0]            group;
   logic                   is_clear;
   rdsn_pkg::step_type     step;
   rdsn_pkg::rsp_word_type result;

   rdsn_csr u_csr (
      .clock         (clock),
      .reset         (reset),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready),
      .double_buffer (double_buffer)
   );

   assign s1_advance = s1_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !s1_valid_ff || s1_advance;
   assign req_accept = req_ch.valid && req_ch.ready;

   always_comb begin
      s1_valid_in = req_accept || (s1_valid_ff && !s1_advance);
      s1_word_in = s1_word_ff;
      if (req_accept) begin
         s1_word_in = '{operation: req_ch.operation, block_b: req_ch.block_b,
                        block_d: req_ch.block_d};
      end
   end

   assign group = s1_word_ff.block_b & rdsn_pkg::GROUP_MASK;
   assign is_clear = (s1_word_ff.operation == rdsn_pkg::OP_CLEAR);

   always_comb begin
      step.enable = s1_advance;
      step.clear = is_clear;
      step.accepted = !is_clear && (group == rdsn_pkg::GROUP_0A || group == rdsn_pkg::GROUP_0B);
      step.row = is_clear ? '0 : s1_word_ff.block_b[rdsn_pkg::ROW_W-1:0];
      step.chars = '{first: s1_word_ff.block_d[15:8], second: s1_word_ff.block_d[7:0]};
   end

   rdsn_name_store u_store (
      .clock         (clock),
      .reset         (reset),
      .double_buffer (double_buffer),
      .step          (step),
      .result        (result)
   );

   always_comb begin
      rsp_valid_in = s1_advance || (rsp_valid_ff && !rsp_ch.ready);
      rsp_word_in = s1_advance ? result : rsp_word_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_word_ff <= s1_word_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.accepted = rsp_word_ff.accepted;
   assign rsp_ch.segment = rsp_word_ff.segment;
   assign rsp_ch.shown_first = rsp_word_ff.shown_first;
   assign rsp_ch.shown_second = rsp_word_ff.shown_second;

   `RDSN_ASSERT_NEXT(a_advance_gives_result, clock, reset, s1_advance, rsp_valid_ff)
   `RDSN_ASSERT_SAME(a_full_blocks_input, clock, reset,
                     s1_valid_ff && rsp_valid_ff && !rsp_ch.ready, !req_ch.ready)
   `RDSN_ASSERT_NEXT(a_clear_result, clock, reset, s1_advance && is_clear,
                     !rsp_word_ff.accepted && rsp_word_ff.segment == '0 &&
                     rsp_word_ff.shown_first == rdsn_pkg::SPACE_CHAR &&
                     rsp_word_ff.shown_second == rdsn_pkg::SPACE_CHAR)

endmodule
